/* hw/rtl/cfd_pkg.sv */
package cfd_pkg;

    // fixed field widths
    localparam int BYTE_W     = 8;
    localparam int LEN_PORT_W = 7;
    localparam int IDX_PORT_W = 6;
    localparam int CFG_IDX_W  = 2;

    // defaults
    localparam int                DEF_MAX_PAYLOAD   = 64;
    localparam logic [BYTE_W-1:0] START_MARKER_INIT = 8'hAA;
    localparam logic [BYTE_W-1:0] END_MARKER_INIT   = 8'h55;

    // crc-16/ccitt-false
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // result status codes
    typedef enum logic [1:0] {
        STAT_PLAIN  = 2'd0,
        STAT_PARSED = 2'd1,
        STAT_FRAME  = 2'd2
    } status_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;

    // one byte through the crc, msb first
    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* hw/rtl/cfd_payload_ram.sv */
module cfd_payload_ram #(
    parameter int DEPTH  = cfd_pkg::DEF_MAX_PAYLOAD,
    parameter int ADDR_W = 6
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [cfd_pkg::BYTE_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [cfd_pkg::BYTE_W-1:0] rd_data
);

    logic [cfd_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [cfd_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/cfd_parser.sv */
module cfd_parser #(
    parameter int MAX_PAYLOAD = cfd_pkg::DEF_MAX_PAYLOAD,
    parameter int LEN_W       = 7,
    parameter int ADDR_W      = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cfd_pkg::BYTE_W-1:0]    start_marker,
    input  logic [cfd_pkg::BYTE_W-1:0]    end_marker,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cfd_pkg::BYTE_W-1:0]    rx_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [cfd_pkg::BYTE_W-1:0]    data_byte,
    output logic [cfd_pkg::BYTE_W-1:0]    frame_command,
    output logic [cfd_pkg::BYTE_W-1:0]    frame_sequence,
    output logic [cfd_pkg::LEN_PORT_W-1:0] payload_length,
    output logic [cfd_pkg::IDX_PORT_W-1:0] byte_index,
    output logic                          last,
    output logic                          ram_wr_en,
    output logic [ADDR_W-1:0]             ram_wr_addr,
    output logic [cfd_pkg::BYTE_W-1:0]    ram_wr_data,
    output logic [ADDR_W-1:0]             ram_rd_addr,
    input  logic [cfd_pkg::BYTE_W-1:0]    ram_rd_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMD,
        S_SEQ,
        S_LEN_LO,
        S_LEN_HI,
        S_PAYLOAD,
        S_CRC_LO,
        S_CRC_HI,
        S_END,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    state_t                       state_reg, state_next;
    logic [cfd_pkg::BYTE_W-1:0]   cmd_reg, cmd_next;
    logic [cfd_pkg::BYTE_W-1:0]   seq_reg, seq_next;
    logic [cfd_pkg::BYTE_W-1:0]   len_lo_reg, len_lo_next;
    logic [LEN_W-1:0]             len_reg, len_next;
    logic [LEN_W-1:0]             cnt_reg, cnt_next;
    logic [15:0]                  crc_reg, crc_next;
    logic [cfd_pkg::BYTE_W-1:0]   crc_lo_reg, crc_lo_next;

    logic                         out_valid_reg, out_valid_next;
    cfd_pkg::status_t             status_reg, status_next;
    logic [cfd_pkg::BYTE_W-1:0]   data_reg, data_next;
    logic [cfd_pkg::BYTE_W-1:0]   ocmd_reg, ocmd_next;
    logic [cfd_pkg::BYTE_W-1:0]   oseq_reg, oseq_next;
    logic [cfd_pkg::LEN_PORT_W-1:0] olen_reg, olen_next;
    logic [cfd_pkg::IDX_PORT_W-1:0] oidx_reg, oidx_next;
    logic                         last_reg, last_next;

    logic                         slot_free;
    logic                         take;
    logic                         emitting;
    logic [15:0]                  length_full;
    logic [LEN_W-1:0]             cnt_inc;

    assign slot_free   = !out_valid_reg || out_ready;
    assign emitting    = (state_reg == S_EMIT_RD) || (state_reg == S_EMIT_OUT);
    assign in_ready    = slot_free && !emitting;
    assign take        = in_valid && in_ready;
    assign length_full = {rx_byte, len_lo_reg};
    assign cnt_inc     = cnt_reg + LEN_W'(1);

    assign ram_wr_addr = cnt_reg[ADDR_W-1:0];
    assign ram_wr_data = rx_byte;
    assign ram_rd_addr = cnt_reg[ADDR_W-1:0];

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        seq_next       = seq_reg;
        len_lo_next    = len_lo_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        crc_next       = crc_reg;
        crc_lo_next    = crc_lo_reg;
        ram_wr_en      = 1'b0;

        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        ocmd_next      = ocmd_reg;
        oseq_next      = oseq_reg;
        olen_next      = olen_reg;
        oidx_next      = oidx_reg;
        last_next      = last_reg;

        // every accepted byte gives a single "consumed" result unless overridden
        if (take) begin
            out_valid_next = 1'b1;
            status_next    = cfd_pkg::STAT_PARSED;
            data_next      = '0;
            ocmd_next      = '0;
            oseq_next      = '0;
            olen_next      = '0;
            oidx_next      = '0;
            last_next      = 1'b1;
        end

        case (state_reg)
            S_IDLE: begin
                if (take) begin
                    if (rx_byte != start_marker) begin
                        status_next = cfd_pkg::STAT_PLAIN;
                        data_next   = rx_byte;
                    end else begin
                        crc_next   = cfd_pkg::crc_add(cfd_pkg::CRC_INIT, rx_byte);
                        state_next = S_CMD;
                    end
                end
            end
            S_CMD: begin
                if (take) begin
                    cmd_next   = rx_byte;
                    crc_next   = cfd_pkg::crc_add(crc_reg, rx_byte);
                    state_next = S_SEQ;
                end
            end
            S_SEQ: begin
                if (take) begin
                    seq_next   = rx_byte;
                    crc_next   = cfd_pkg::crc_add(crc_reg, rx_byte);
                    state_next = S_LEN_LO;
                end
            end
            S_LEN_LO: begin
                if (take) begin
                    len_lo_next = rx_byte;
                    crc_next    = cfd_pkg::crc_add(crc_reg, rx_byte);
                    state_next  = S_LEN_HI;
                end
            end
            S_LEN_HI: begin
                if (take) begin
                    crc_next = cfd_pkg::crc_add(crc_reg, rx_byte);
                    cnt_next = '0;
                    if (length_full > 16'(MAX_PAYLOAD)) begin
                        // oversize length: back to idle to resync, with the usual consumed result
                        state_next = S_IDLE;
                    end else begin
                        len_next = length_full[LEN_W-1:0];
                        if (length_full == 16'd0)
                            state_next = S_CRC_LO;
                        else
                            state_next = S_PAYLOAD;
                    end
                end
            end
            S_PAYLOAD: begin
                if (take) begin
                    ram_wr_en = 1'b1;
                    crc_next  = cfd_pkg::crc_add(crc_reg, rx_byte);
                    cnt_next  = cnt_inc;
                    if (cnt_inc == len_reg)
                        state_next = S_CRC_LO;
                end
            end
            S_CRC_LO: begin
                if (take) begin
                    crc_lo_next = rx_byte;
                    state_next  = S_CRC_HI;
                end
            end
            S_CRC_HI: begin
                if (take) begin
                    // residue is zero on a match
                    crc_next   = crc_reg ^ {rx_byte, crc_lo_reg};
                    state_next = S_END;
                end
            end
            S_END: begin
                if (take) begin
                    state_next = S_IDLE;
                    if (rx_byte == end_marker && crc_reg == 16'd0) begin
                        if (len_reg == '0) begin
                            status_next = cfd_pkg::STAT_FRAME;
                            ocmd_next   = cmd_reg;
                            oseq_next   = seq_reg;
                        end else begin
                            // payload run replaces the single result
                            out_valid_next = out_ready ? 1'b0 : out_valid_reg;
                            cnt_next       = '0;
                            state_next     = S_EMIT_RD;
                        end
                    end
                end
            end
            S_EMIT_RD: begin
                // ram address settles, data registered next cycle
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    status_next    = cfd_pkg::STAT_FRAME;
                    data_next      = ram_rd_data;
                    ocmd_next      = cmd_reg;
                    oseq_next      = seq_reg;
                    olen_next      = cfd_pkg::LEN_PORT_W'(len_reg);
                    oidx_next      = cfd_pkg::IDX_PORT_W'(cnt_reg);
                    last_next      = (cnt_inc == len_reg);
                    cnt_next       = cnt_inc;
                    state_next     = (cnt_inc == len_reg) ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            seq_reg       <= '0;
            len_lo_reg    <= '0;
            len_reg       <= '0;
            cnt_reg       <= '0;
            crc_reg       <= cfd_pkg::CRC_INIT;
            crc_lo_reg    <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= cfd_pkg::STAT_PLAIN;
            data_reg      <= '0;
            ocmd_reg      <= '0;
            oseq_reg      <= '0;
            olen_reg      <= '0;
            oidx_reg      <= '0;
            last_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            seq_reg       <= seq_next;
            len_lo_reg    <= len_lo_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            crc_reg       <= crc_next;
            crc_lo_reg    <= crc_lo_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            data_reg      <= data_next;
            ocmd_reg      <= ocmd_next;
            oseq_reg      <= oseq_next;
            olen_reg      <= olen_next;
            oidx_reg      <= oidx_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign data_byte      = data_reg;
    assign frame_command  = ocmd_reg;
    assign frame_sequence = oseq_reg;
    assign payload_length = olen_reg;
    assign byte_index     = oidx_reg;
    assign last           = last_reg;

endmodule

/* hw/rtl/command_frame_deframer.sv */
// channel   direction  handshake              payload
// -------   ---------  ---------------------  ------------------------------------------
// in        sink       in_valid / in_ready    rx_byte
// out       source     out_valid / out_ready  status, data_byte, frame_command,
//                                             frame_sequence, payload_length,
//                                             byte_index, last
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one received byte is taken per cycle while the output register is free or being
// drained; its result is registered straight into the output register
// a good frame with n payload bytes, n >= 1, emits its run one byte at a time, each a
// payload ram read then an output load, held while the output stalls; input is held off during the run
// rst_n is asynchronous: parser goes idle, markers return to their defaults;
// the payload ram has no reset and needs no clearing pass
// out_ready low stalls the output register and, through it, the input

module command_frame_deframer #(
    parameter int MAX_PAYLOAD = cfd_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // received bytes
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [cfd_pkg::BYTE_W-1:0]     rx_byte,

    // results
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [cfd_pkg::BYTE_W-1:0]     data_byte,
    output logic [cfd_pkg::BYTE_W-1:0]     frame_command,
    output logic [cfd_pkg::BYTE_W-1:0]     frame_sequence,
    output logic [cfd_pkg::LEN_PORT_W-1:0] payload_length,
    output logic [cfd_pkg::IDX_PORT_W-1:0] byte_index,
    output logic                           last,

    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfd_pkg::BYTE_W-1:0]     cfg_data
);

    // payload counter holds 0..MAX_PAYLOAD, ram address covers 0..MAX_PAYLOAD-1
    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [cfd_pkg::BYTE_W-1:0] start_marker_reg;
    logic [cfd_pkg::BYTE_W-1:0] end_marker_reg;

    logic                       ram_wr_en;
    logic [ADDR_W-1:0]          ram_wr_addr;
    logic [cfd_pkg::BYTE_W-1:0] ram_wr_data;
    logic [ADDR_W-1:0]          ram_rd_addr;
    logic [cfd_pkg::BYTE_W-1:0] ram_rd_data;

    // register writes always complete in one transaction
    assign cfg_ready = 1'b1;

    // marker registers; writes to unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start_marker_reg <= cfd_pkg::START_MARKER_INIT;
            end_marker_reg   <= cfd_pkg::END_MARKER_INIT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cfd_pkg::CFG_START_MARKER: start_marker_reg <= cfg_data;
                cfd_pkg::CFG_END_MARKER:   end_marker_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // header fields, crc and sequencing; payload goes to the ram as it arrives
    cfd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .LEN_W       (LEN_W),
        .ADDR_W      (ADDR_W)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .start_marker   (start_marker_reg),
        .end_marker     (end_marker_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .data_byte      (data_byte),
        .frame_command  (frame_command),
        .frame_sequence (frame_sequence),
        .payload_length (payload_length),
        .byte_index     (byte_index),
        .last           (last),
        .ram_wr_en      (ram_wr_en),
        .ram_wr_addr    (ram_wr_addr),
        .ram_wr_data    (ram_wr_data),
        .ram_rd_addr    (ram_rd_addr),
        .ram_rd_data    (ram_rd_data)
    );

    // writes happen only while collecting and read data is used only while emitting,
    // so a read of an entry in the same cycle as its write is never used
    cfd_payload_ram #(
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (ADDR_W)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

/* tb/command_frame_deframer_test.sv */
module command_frame_deframer_test;

    import cfd_pkg::*;

    // run bounds
    localparam int MAX_PAYLOAD = DEF_MAX_PAYLOAD;
    localparam int HDR_BYTES   = 5;       // start, command, sequence, two length bytes
    localparam int CYCLE_LIMIT = 100000;  // watchdog bound on the whole run

    // ways a generated frame can be broken
    typedef enum {
        FLAW_NONE,
        FLAW_CRC,
        FLAW_END,
        FLAW_LENGTH,
        FLAW_CUT
    } frame_flaw_t;

    typedef logic [7:0] byte_q_t[$];

    // one expected output transaction
    typedef struct {
        status_t    kind;
        logic [7:0] data;
        logic [7:0] command;
        logic [7:0] sequence_no;
        logic [6:0] count;
        logic [5:0] index;
        logic       is_last;
    } outcome_t;

    logic clk;
    logic rst_n;

    logic                 in_valid;
    logic                 in_ready;
    logic [BYTE_W-1:0]    rx_byte;

    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           status;
    logic [BYTE_W-1:0]    data_byte;
    logic [BYTE_W-1:0]    frame_command;
    logic [BYTE_W-1:0]    frame_sequence;
    logic [LEN_PORT_W-1:0] payload_length;
    logic [IDX_PORT_W-1:0] byte_index;
    logic                 last;

    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    // deframer copy: parser state and marker registers as the block should hold them
    int         parse_pos;
    logic [7:0] got_command;
    logic [7:0] got_sequence;
    logic [15:0] got_length;
    logic [7:0] payload_copy[MAX_PAYLOAD];
    logic [15:0] crc_acc;
    logic [7:0] crc_low_byte;
    logic [7:0] cur_start = START_MARKER_INIT;
    logic [7:0] cur_end   = END_MARKER_INIT;

    // markers as the stimulus side last wrote them
    logic [7:0] open_byte  = START_MARKER_INIT;
    logic [7:0] close_byte = END_MARKER_INIT;

    // outputs still owed by the block, oldest first
    outcome_t pending_outputs[$];

    int  mismatches;
    int  bytes_sent;
    int  cycle_count;
    bit  in_gaps_on;
    bit  out_stalls_on;

    command_frame_deframer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .data_byte      (data_byte),
        .frame_command  (frame_command),
        .frame_sequence (frame_sequence),
        .payload_length (payload_length),
        .byte_index     (byte_index),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // deframer prediction
    // ------------------------------------------------------------------

    // crc-16/ccitt-false, one input bit at a time
    function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        int          i;
        r = acc;
        for (i = 7; i >= 0; i--)
        begin
            if (r[15] ^ b[i])
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

    function automatic void owe(input status_t kind, input logic [7:0] data,
                                input logic [7:0] command, input logic [7:0] sequence_no,
                                input logic [6:0] count, input logic [5:0] index,
                                input logic is_last);
        outcome_t o;
        o.kind        = kind;
        o.data        = data;
        o.command     = command;
        o.sequence_no = sequence_no;
        o.count       = count;
        o.index       = index;
        o.is_last     = is_last;
        pending_outputs.push_back(o);
    endfunction

    // advance the parser copy by one accepted byte and queue what it must emit
    function automatic void deframe_byte(input logic [7:0] b);
        int p;
        int i;
        if (parse_pos == 0)
        begin
            if (b != cur_start)
            begin
                owe(STAT_PLAIN, b, 8'h00, 8'h00, 7'd0, 6'd0, 1'b1);
                return;
            end
            crc_acc   = crc16_next(CRC_INIT, b);
            parse_pos = 1;
        end
        else if (parse_pos < HDR_BYTES)
        begin
            case (parse_pos)
                1:       got_command       = b;
                2:       got_sequence      = b;
                3:       got_length[7:0]   = b;
                default: got_length[15:8]  = b;
            endcase
            crc_acc   = crc16_next(crc_acc, b);
            parse_pos = parse_pos + 1;
            // oversized length: back to hunting for a start byte
            if (parse_pos == HDR_BYTES && got_length > MAX_PAYLOAD)
                parse_pos = 0;
        end
        else
        begin
            p = parse_pos - HDR_BYTES;
            if (p < got_length)
            begin
                payload_copy[p] = b;
                crc_acc         = crc16_next(crc_acc, b);
                parse_pos       = parse_pos + 1;
            end
            else if (p == got_length)
            begin
                crc_low_byte = b;
                parse_pos    = parse_pos + 1;
            end
            else if (p == got_length + 1)
            begin
                // received crc folded in, so a match leaves zero
                crc_acc   = crc_acc ^ {b, crc_low_byte};
                parse_pos = parse_pos + 1;
            end
            else
            begin
                parse_pos = 0;
                if (b == cur_end && crc_acc == 16'h0000)
                begin
                    if (got_length == 0)
                        owe(STAT_FRAME, 8'h00, got_command, got_sequence, 7'd0, 6'd0, 1'b1);
                    else
                        for (i = 0; i < got_length; i++)
                            owe(STAT_FRAME, payload_copy[i], got_command, got_sequence,
                                got_length[6:0], i[5:0], (i + 1 == got_length));
                    return;
                end
            end
        end
        owe(STAT_PARSED, 8'h00, 8'h00, 8'h00, 7'd0, 6'd0, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    function automatic void check_field(input string what, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want_v, got_v);
            mismatches++;
        end
    endfunction

    function automatic void check_output();
        outcome_t want;
        if (pending_outputs.size() == 0)
        begin
            $display("%0t: output transaction with nothing expected: status %0h data %0h",
                     $time, status, data_byte);
            mismatches++;
            return;
        end
        want = pending_outputs.pop_front();
        check_field("status", 8'(want.kind), 8'(status));
        check_field("data_byte", want.data, data_byte);
        check_field("frame_command", want.command, frame_command);
        check_field("frame_sequence", want.sequence_no, frame_sequence);
        check_field("payload_length", 8'(want.count), 8'(payload_length));
        check_field("byte_index", 8'(want.index), 8'(byte_index));
        check_field("last", 8'(want.is_last), 8'(last));
    endfunction

    // one monitor for all three channels: outputs retire first, then register
    // writes, then the accepted byte is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_output();
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_START_MARKER)
                    cur_start = cfg_data;
                else if (cfg_index == CFG_END_MARKER)
                    cur_end = cfg_data;
            end
            if (in_valid && in_ready)
                deframe_byte(rx_byte);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d output transactions still owed",
                     $time, pending_outputs.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // output back-pressure: random stall bursts while enabled
    // ------------------------------------------------------------------

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_stalls_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one input transaction; valid is left high so a following call keeps the
    // stream back to back, anything that waits must lower it first
    task automatic send_byte(input logic [7:0] b);
        if (in_gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        bytes_sent++;
    endtask

    // stop sending and wait until every owed output has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_outputs.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == CFG_START_MARKER)
            open_byte = value;
        else
            close_byte = value;
    endtask

    // build a frame around the payload with the current markers, optionally broken
    task automatic send_frame(input frame_flaw_t flaw, input logic [7:0] command,
                              input logic [7:0] sequence_no, input byte_q_t payload);
        logic [7:0]  frame_bytes[$];
        logic [15:0] len_field;
        logic [15:0] crc;
        int          stop_at;
        int          i;
        len_field = 16'(payload.size());
        if (flaw == FLAW_LENGTH)
            len_field = $urandom_range(0, 1) ? 16'($urandom_range(MAX_PAYLOAD + 1, 255))
                                             : 16'($urandom_range(256, 16'hFFFF));
        frame_bytes = {open_byte, command, sequence_no, len_field[7:0], len_field[15:8]};
        if (flaw != FLAW_LENGTH)
        begin
            for (i = 0; i < payload.size(); i++)
                frame_bytes.push_back(payload[i]);
            crc = CRC_INIT;
            for (i = 0; i < frame_bytes.size(); i++)
                crc = crc16_next(crc, frame_bytes[i]);
            if (flaw == FLAW_CRC)
                crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
            frame_bytes.push_back(crc[7:0]);
            frame_bytes.push_back(crc[15:8]);
            if (flaw == FLAW_END)
                frame_bytes.push_back(close_byte ^ 8'($urandom_range(1, 255)));
            else
                frame_bytes.push_back(close_byte);
        end
        // a cut frame just stops; whatever comes next is taken as its continuation
        stop_at = frame_bytes.size();
        if (flaw == FLAW_CUT)
            stop_at = $urandom_range(1, frame_bytes.size() - 1);
        for (i = 0; i < stop_at; i++)
            send_byte(frame_bytes[i]);
    endtask

    // mostly good frames with random content, plus noise and broken frames
    task automatic run_mixed_traffic(input int item_goal, input bit with_idling);
        byte_q_t    payload;
        logic [7:0] b;
        int         goal;
        int         pick;
        int         n;
        goal = bytes_sent + item_goal;
        while (bytes_sent < goal)
        begin
            // idle-free stretches show up between bursty ones
            in_gaps_on    = with_idling && ($urandom_range(0, 3) != 0);
            out_stalls_on = with_idling && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == open_byte)
                        b = ~b;
                    send_byte(b);
                end
            end
            else
            begin
                payload.delete();
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
                repeat (n) payload.push_back(8'($urandom_range(0, 255)));
                send_frame(pick < 75 ? FLAW_NONE :
                           pick < 82 ? FLAW_CRC :
                           pick < 89 ? FLAW_END :
                           pick < 95 ? FLAW_LENGTH : FLAW_CUT,
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), payload);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // bytes outside a frame come straight back as plain
    task automatic test_plain_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    // empty payload gives a single frame result, a two byte payload gives a run
    task automatic test_good_frames();
        byte_q_t payload;
        send_frame(FLAW_NONE, 8'hFF, 8'h00, payload);
        payload = '{8'h00, 8'hFF};
        send_frame(FLAW_NONE, 8'h00, 8'hFF, payload);
    endtask

    // length one above the maximum: parser drops back to idle after the header
    task automatic test_oversize_length();
        send_byte(open_byte);
        send_byte(8'h5A);
        send_byte(8'hA5);
        send_byte(8'(MAX_PAYLOAD + 1));
        send_byte(8'h00);
    endtask

    // crc mismatch: frame swallowed without a frame result
    task automatic test_bad_crc();
        byte_q_t payload;
        send_frame(FLAW_CRC, 8'h3C, 8'hC3, payload);
    endtask

    // marker registers at their extremes, random values, equal values, then defaults
    task automatic test_marker_settings();
        logic [7:0] m;
        write_register(CFG_START_MARKER, 8'h00);
        write_register(CFG_END_MARKER, 8'hFF);
        run_mixed_traffic(30, 1'b1);
        write_register(CFG_START_MARKER, 8'hFF);
        write_register(CFG_END_MARKER, 8'h00);
        run_mixed_traffic(30, 1'b1);
        write_register(CFG_START_MARKER, 8'($urandom_range(0, 255)));
        write_register(CFG_END_MARKER, 8'($urandom_range(0, 255)));
        run_mixed_traffic(30, 1'b1);
        m = 8'($urandom_range(0, 255));
        write_register(CFG_START_MARKER, m);
        write_register(CFG_END_MARKER, m);
        run_mixed_traffic(30, 1'b1);
        write_register(CFG_START_MARKER, START_MARKER_INIT);
        write_register(CFG_END_MARKER, END_MARKER_INIT);
        run_mixed_traffic(30, 1'b1);
    endtask

    task automatic test_random_traffic();
        run_mixed_traffic(60, 1'b1);
    endtask

    // closing stretch with no idling on either side, led by a full length payload
    task automatic test_back_to_back();
        byte_q_t payload;
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        repeat (MAX_PAYLOAD) payload.push_back(8'($urandom_range(0, 255)));
        send_frame(FLAW_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   payload);
        run_mixed_traffic(20, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = 8'h00;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_START_MARKER;
        cfg_data      = 8'h00;
        parse_pos     = 0;
        crc_acc       = CRC_INIT;
        mismatches    = 0;
        bytes_sent    = 0;
        cycle_count   = 0;
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_plain_bytes();
        test_good_frames();
        test_oversize_length();
        test_bad_crc();
        test_marker_settings();
        test_random_traffic();
        test_back_to_back();

        drain_results();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/cfd_pkg.sv
hw/rtl/cfd_payload_ram.sv
hw/rtl/cfd_parser.sv
hw/rtl/command_frame_deframer.sv
tb/command_frame_deframer_test.sv
